[hdl/bfbp_pkg.sv]
// ----------------------------------------------------------------------------
// bfbp_pkg
// Shared types and constants for the best-fit bin packer.
// ----------------------------------------------------------------------------
package bfbp_pkg;

  localparam int unsigned BFBP_MAX_BINS = 1024;
  localparam int unsigned SIZE_W        = 40;
  localparam int unsigned IDX_OUT_W     = 10;

  localparam logic [SIZE_W-1:0] DEFAULT_CAPACITY = SIZE_W'(64'd104857600);

  localparam logic [1:0] STATUS_PLACED   = 2'd0;
  localparam logic [1:0] STATUS_OVERSIZE = 2'd1;
  localparam logic [1:0] STATUS_NO_BIN   = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0] item_size;
    logic              last_item;
  } bfbp_in_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] bin_index;
    logic                 opened_new;
    logic [SIZE_W-1:0]    bin_fill;
    logic [1:0]           status;
    logic                 job_end;
  } bfbp_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } bfbp_state_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic commit;
  } bfbp_cmd_t;

  typedef struct packed {
    logic skip_scan;
    logic scan_last;
    logic out_free;
  } bfbp_stat_t;

endpackage

[hdl/bfbp_ctrl.sv]
// ----------------------------------------------------------------------------
// bfbp_ctrl
// Sequencer that loads a word, scans the open bins and commits the result.
// ----------------------------------------------------------------------------
module bfbp_ctrl
  import bfbp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  bfbp_stat_t stat_i,
  output bfbp_cmd_t  cmd_o
);

  bfbp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat_i.skip_scan) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.rd = 1'b1;
          if (stat_i.scan_last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/bfbp_datapath.sv]
// ----------------------------------------------------------------------------
// bfbp_datapath
// Fill memory, best-fit comparator, bin counter and result register.
// ----------------------------------------------------------------------------
module bfbp_datapath
  import bfbp_pkg::*;
#(
  parameter int unsigned MAX_BINS = BFBP_MAX_BINS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  input  bfbp_in_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bfbp_out_t         out_word_o,
  input  bfbp_cmd_t         cmd_i,
  output bfbp_stat_t        stat_o
);

  localparam int unsigned IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BINS + 1);

  logic [SIZE_W-1:0] fill_mem [MAX_BINS];

  logic [SIZE_W-1:0] cap_q;
  logic [CNT_W-1:0]  bins_open_q;
  logic              out_valid_q;
  bfbp_out_t         out_word_q;

  logic [SIZE_W-1:0] size_q;
  logic              last_q;
  logic              oversize_q;
  logic [IDX_W-1:0]  scan_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic              cmp_vld_q;
  logic [SIZE_W-1:0] rd_data_q;
  logic              found_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [SIZE_W-1:0] best_fill_q;
  logic [SIZE_W-1:0] best_room_q;

  logic [SIZE_W-1:0]       room;
  logic                    fits;
  logic                    room_left;
  logic                    placed;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [SIZE_W-1:0]       wr_data;
  logic [IDX_W+IDX_OUT_W-1:0] idx_wide;
  bfbp_out_t               result;

  assign room      = cap_q - rd_data_q;
  assign fits      = cmp_vld_q && (rd_data_q <= cap_q) && (room >= size_q)
                     && (room < best_room_q);
  assign room_left = bins_open_q < CNT_W'(MAX_BINS);
  assign placed    = !oversize_q && (found_q || room_left);
  assign wr_en     = cmd_i.commit && placed;
  assign wr_addr   = found_q ? best_idx_q : bins_open_q[IDX_W-1:0];
  assign wr_data   = found_q ? SIZE_W'(best_fill_q + size_q) : size_q;
  assign idx_wide  = {{IDX_OUT_W{1'b0}}, wr_addr};

  always_comb begin
    result          = '0;
    result.job_end  = last_q;
    if (oversize_q) begin
      result.status = STATUS_OVERSIZE;
    end else if (placed) begin
      result.status     = STATUS_PLACED;
      result.bin_index  = idx_wide[IDX_OUT_W-1:0];
      result.opened_new = !found_q;
      result.bin_fill   = wr_data;
    end else begin
      result.status = STATUS_NO_BIN;
    end
  end

  assign stat_o.skip_scan = oversize_q || (bins_open_q == '0);
  assign stat_o.scan_last = (CNT_W'(scan_q) + CNT_W'(1)) == bins_open_q;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= DEFAULT_CAPACITY;
      bins_open_q <= '0;
      out_valid_q <= 1'b0;
      cmp_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      cmp_vld_q <= cmd_i.rd;
      if (cmd_i.commit) begin
        if (last_q) begin
          bins_open_q <= '0;
        end else if (placed && !found_q) begin
          bins_open_q <= bins_open_q + CNT_W'(1);
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      size_q      <= in_word_i.item_size;
      last_q      <= in_word_i.last_item;
      oversize_q  <= in_word_i.item_size > cap_q;
      scan_q      <= '0;
      found_q     <= 1'b0;
      best_room_q <= cap_q;
    end else begin
      if (cmd_i.rd) begin
        scan_q <= scan_q + IDX_W'(1);
      end
      if (fits) begin
        found_q     <= 1'b1;
        best_idx_q  <= cmp_idx_q;
        best_fill_q <= rd_data_q;
        best_room_q <= room;
      end
    end
    if (cmd_i.rd) begin
      cmp_idx_q <= scan_q;
    end
    if (cmd_i.commit) begin
      out_word_q <= result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_data_q <= fill_mem[scan_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fill_mem[wr_addr] <= wr_data;
    end
  end

endmodule

[hdl/best_fit_bin_packer.sv]
// ----------------------------------------------------------------------------
// best_fit_bin_packer
// Places each incoming item in the open bin with the tightest fit, opening a new bin when none fits.
// ----------------------------------------------------------------------------
// The input channel carries one item size and a last-item mark per word; the
// output channel returns one result word per input word, in order. Both use
// valid and stall, and a word moves when valid is high and stall is low.
// The bin capacity is written through cfg_we_i and cfg_wdata_i; the user
// must write it only while idle, since the block does not enforce this.
// Each item reads the fill memory once per open bin through a single read
// port and one comparator. Oversized items and items arriving with no open
// bin skip the scan.
// The result sits in an output register; a new input word is accepted while
// that result waits. A stalled receiver holds the packer in its commit step
// until the waiting result is taken, and the input then stays stalled.
// Reset sets the capacity to 100 MiB and closes all bins; the fill memory
// needs no clearing since only bins opened since the last job end are read.
// ----------------------------------------------------------------------------
module best_fit_bin_packer
  import bfbp_pkg::*;
#(
  parameter int unsigned MAX_BINS = BFBP_MAX_BINS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bfbp_in_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bfbp_out_t         out_word_o
);

  bfbp_cmd_t  cmd;
  bfbp_stat_t stat;

  bfbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bfbp_datapath #(
    .MAX_BINS (MAX_BINS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
